// ===== src/skf_pkg.sv =====
// shared types, constants and reset values for the scalar kalman filter block
// no dependencies; every other file in src imports this package
`default_nettype none

package skf_pkg;

  // fixed field widths
  localparam int CH_W    = 2;
  localparam int DATA_W  = 24;
  localparam int DIFF_W  = DATA_W + 1;
  localparam int ACC_W   = DATA_W + 2;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  // default parameter values
  localparam int CHANNELS_DEF  = 4;
  localparam int FRAC_BITS_DEF = 16;

  // register reset values
  localparam logic [DATA_W-1:0] QXYZ_RST  = 24'd6554;
  localparam logic [DATA_W-1:0] QTEMP_RST = 24'd1311;
  localparam logic [DATA_W-1:0] RXYZ_RST  = 24'd131072;
  localparam logic [DATA_W-1:0] RTEMP_RST = 24'd32768;

  // register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_PROCESS_NOISE_X    = 3'd0,
    REG_PROCESS_NOISE_Y    = 3'd1,
    REG_PROCESS_NOISE_Z    = 3'd2,
    REG_PROCESS_NOISE_TEMP = 3'd3,
    REG_MEASURE_NOISE_X    = 3'd4,
    REG_MEASURE_NOISE_Y    = 3'd5,
    REG_MEASURE_NOISE_Z    = 3'd6,
    REG_MEASURE_NOISE_TEMP = 3'd7
  } reg_idx_t;

  // channel codes
  localparam logic [CH_W-1:0] CH_X    = 2'd0;
  localparam logic [CH_W-1:0] CH_Y    = 2'd1;
  localparam logic [CH_W-1:0] CH_Z    = 2'd2;
  localparam logic [CH_W-1:0] CH_TEMP = 2'd3;

  // input and result words
  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic signed [DATA_W-1:0] measurement;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]          channel_out;
    logic signed [DATA_W-1:0] estimate;
    logic                     error;
  } out_word_t;

  // noise pair of the selected channel
  typedef struct packed {
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] r;
  } noise_t;

  // estimate reset per channel: 0, 0, 1000.0, 1048.0 in Q16.8
  function automatic logic signed [DATA_W-1:0] est_reset(input int idx);
    logic signed [DATA_W-1:0] v;
    case (idx)
      2:       v = 24'sd256000;
      3:       v = 24'sd268288;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/skf_regs.sv =====
// noise register file behind the apb-style port, plus per-channel noise select
// depends on skf_pkg
`default_nettype none

module skf_regs
  import skf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic [CH_W-1:0]   sel_ch,
  output noise_t                 noise
);

  logic [DATA_W-1:0] process_noise_x_r, process_noise_y_r;
  logic [DATA_W-1:0] process_noise_z_r, process_noise_temp_r;
  logic [DATA_W-1:0] measure_noise_x_r, measure_noise_y_r;
  logic [DATA_W-1:0] measure_noise_z_r, measure_noise_temp_r;
  reg_idx_t          idx;
  logic              wr_en;
  logic [DATA_W-1:0] rd_val;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      process_noise_x_r    <= QXYZ_RST;
      process_noise_y_r    <= QXYZ_RST;
      process_noise_z_r    <= QXYZ_RST;
      process_noise_temp_r <= QTEMP_RST;
      measure_noise_x_r    <= RXYZ_RST;
      measure_noise_y_r    <= RXYZ_RST;
      measure_noise_z_r    <= RXYZ_RST;
      measure_noise_temp_r <= RTEMP_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PROCESS_NOISE_X:    process_noise_x_r    <= pwdata[DATA_W-1:0];
        REG_PROCESS_NOISE_Y:    process_noise_y_r    <= pwdata[DATA_W-1:0];
        REG_PROCESS_NOISE_Z:    process_noise_z_r    <= pwdata[DATA_W-1:0];
        REG_PROCESS_NOISE_TEMP: process_noise_temp_r <= pwdata[DATA_W-1:0];
        REG_MEASURE_NOISE_X:    measure_noise_x_r    <= pwdata[DATA_W-1:0];
        REG_MEASURE_NOISE_Y:    measure_noise_y_r    <= pwdata[DATA_W-1:0];
        REG_MEASURE_NOISE_Z:    measure_noise_z_r    <= pwdata[DATA_W-1:0];
        REG_MEASURE_NOISE_TEMP: measure_noise_temp_r <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_PROCESS_NOISE_X:    rd_val = process_noise_x_r;
      REG_PROCESS_NOISE_Y:    rd_val = process_noise_y_r;
      REG_PROCESS_NOISE_Z:    rd_val = process_noise_z_r;
      REG_PROCESS_NOISE_TEMP: rd_val = process_noise_temp_r;
      REG_MEASURE_NOISE_X:    rd_val = measure_noise_x_r;
      REG_MEASURE_NOISE_Y:    rd_val = measure_noise_y_r;
      REG_MEASURE_NOISE_Z:    rd_val = measure_noise_z_r;
      REG_MEASURE_NOISE_TEMP: rd_val = measure_noise_temp_r;
      default:                rd_val = '0;
    endcase
  end

  assign prdata = {{(APB_DW-DATA_W){1'b0}}, rd_val};

  // noise pair for the channel being filtered
  always_comb begin
    case (sel_ch)
      CH_X:    noise = '{q: process_noise_x_r,    r: measure_noise_x_r};
      CH_Y:    noise = '{q: process_noise_y_r,    r: measure_noise_y_r};
      CH_Z:    noise = '{q: process_noise_z_r,    r: measure_noise_z_r};
      CH_TEMP: noise = '{q: process_noise_temp_r, r: measure_noise_temp_r};
      default: noise = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/skf_div.sv =====
// bit-serial restoring divider for the gain: k = floor(num * 2^FRAC_BITS / den)
// one quotient bit per cycle; num <= den assumed; depends on skf_pkg
`default_nettype none

module skf_div
  import skf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DATA_W-1:0]   num,
  input  wire logic [DATA_W:0]     den,
  output logic                     done,
  output logic [FRAC_BITS:0]       quo
);

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DATA_W:0]   rem_r, rem_nxt;
  logic [DATA_W:0]   den_r, den_nxt;
  logic [FRAC_BITS:0] quo_r, quo_nxt;
  logic [DATA_W+1:0] cand;
  logic              ge;

  // first step compares the numerator itself, later steps the doubled remainder
  always_comb begin
    cand = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge   = cand >= {1'b0, den_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, which may need all DATA_W+1 bits
      rem_nxt = ge ? (DATA_W+1)'(cand - {1'b0, den_r}) : cand[DATA_W:0];
      quo_nxt = {quo_r[FRAC_BITS-1:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(FRAC_BITS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ===== src/skf_mul.sv =====
// bit-serial shift-add multiplier: signed multiplicand times unsigned FRAC_BITS+1 bit
// multiplier, lsb first, one bit per cycle; product = acc * 2^(FRAC_BITS+1) + lo
// depends on skf_pkg
`default_nettype none

module skf_mul
  import skf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [DIFF_W-1:0] mcand,
  input  wire logic [FRAC_BITS:0]       mplier,
  output logic                          done,
  output logic signed [ACC_W-1:0]       acc,
  output logic [FRAC_BITS:0]            lo
);

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic signed [DIFF_W-1:0] mc_r, mc_nxt;
  logic [FRAC_BITS:0]       mp_r, mp_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [FRAC_BITS:0]       lo_r, lo_nxt;
  logic signed [ACC_W-1:0]  sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum = acc_r + (mp_r[0] ? ACC_W'(mc_r) : '0);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    acc_nxt  = acc_r;
    lo_nxt   = lo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      mc_nxt   = mcand;
      mp_nxt   = mplier;
      acc_nxt  = '0;
      lo_nxt   = '0;
    end else if (busy_r) begin
      // arithmetic shift right, low bit drops into the low word
      acc_nxt = {sum[ACC_W-1], sum[ACC_W-1:1]};
      lo_nxt  = {sum[0], lo_r[FRAC_BITS:1]};
      mp_nxt  = {1'b0, mp_r[FRAC_BITS:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(FRAC_BITS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    acc_r <= acc_nxt;
    lo_r  <= lo_nxt;
  end

  assign done = done_r;
  assign acc  = acc_r;
  assign lo   = lo_r;

endmodule

`default_nettype wire

// ===== src/scalar_kalman_filter_channels_core.sv =====
// scalar kalman filter shared by several sensor channels
// one sample word in, one estimate word out; uses skf_pkg, skf_regs, skf_div, skf_mul
//
// usage:
//   in channel  : in_valid / in_stall / in_word {channel, measurement Q16.8}
//   out channel : out_valid / out_stall / out_word {channel_out, estimate, error}
//   config      : apb-style port, eight 24-bit noise registers at 4*i, pready tied high
// per sample: p += q (saturating), k = p/(p+r), x += k*(m-x) rounded, p = (1-k)p
// timing: an accepted sample steps through load, divide, multiply and finish, and
//   only then is the next one accepted; the gain divider and the two update
//   multipliers each retire one bit per cycle, the two multipliers in parallel
//   a zero divisor or a channel that is not present skips to finish with error set
// one sample is in flight at a time; in_stall is high while it is worked on
// results wait in an output register, so a new sample is taken while a result is unread;
//   if the receiver stalls, a finished result holds inside until the register frees up
// reset: estimates reload 0, 0, 1000.0, 1048.0, covariances 2.0, noise registers
//   their defaults; no result is pending
`default_nettype none

module scalar_kalman_filter_channels_core
  import skf_pkg::*;
#(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_word_t          in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_word_t              out_word,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam logic [DATA_W+1:0]  COV_TWO = (DATA_W+2)'(2) << FRAC_BITS;
  localparam logic [DATA_W-1:0]  COV_RST = (COV_TWO > (DATA_W+2)'(24'hFFFFFF)) ?
                                           24'hFFFFFF : COV_TWO[DATA_W-1:0];
  localparam logic [FRAC_BITS:0] ONE     = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic signed [DATA_W+3:0] S24_MAX = 28'sd8388607;
  localparam logic signed [DATA_W+3:0] S24_MIN = -28'sd8388608;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic signed [DATA_W-1:0] est_r [CHANNELS];
  logic [DATA_W-1:0]        cov_r [CHANNELS];
  logic [CH_W-1:0]          ch_r, ch_nxt;
  logic signed [DATA_W-1:0] m_r, m_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic [DATA_W-1:0]        p1_r, p1_nxt;
  out_word_t                res_r, res_nxt;
  out_word_t                out_word_r, out_word_nxt;
  logic                     out_valid_r, out_valid_nxt;

  noise_t                   noise;
  logic signed [DATA_W-1:0] x_rd;
  logic [DATA_W-1:0]        cov_rd;
  logic                     ch_ok;
  logic [DATA_W:0]          p1_sum;
  logic [DATA_W-1:0]        p1;
  logic [DATA_W:0]          den;
  logic                     div_start, div_done;
  logic [FRAC_BITS:0]       k;
  logic                     mul_start;
  logic signed [DIFF_W-1:0] diff;
  logic [FRAC_BITS:0]       omk;
  logic                     mx_done, mp_done;
  logic signed [ACC_W-1:0]  mx_acc, mp_acc;
  logic [FRAC_BITS:0]       mx_lo, mp_lo;
  logic signed [DATA_W+3:0] xn_wide;
  logic signed [DATA_W-1:0] xn;
  logic [DATA_W-1:0]        pn;
  logic                     wr_state;
  logic                     out_free;

  // noise registers
  skf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sel_ch  (ch_r),
    .noise   (noise)
  );

  // channel state read
  always_comb begin
    x_rd   = '0;
    cov_rd = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(ch_r) == i) begin
        x_rd   = est_r[i];
        cov_rd = cov_r[i];
      end
    end
  end

  assign ch_ok = int'(ch_r) < CHANNELS;

  // predicted covariance and divisor
  assign p1_sum = {1'b0, cov_rd} + {1'b0, noise.q};
  assign p1     = p1_sum[DATA_W] ? 24'hFFFFFF : p1_sum[DATA_W-1:0];
  assign den    = {1'b0, p1} + {1'b0, noise.r};

  skf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (p1),
    .den   (den),
    .done  (div_done),
    .quo   (k)
  );

  // innovation and 1 - k
  assign diff = {m_r[DATA_W-1], m_r} - {x_r[DATA_W-1], x_r};
  assign omk  = ONE - k;

  skf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (diff),
    .mplier (k),
    .done   (mx_done),
    .acc    (mx_acc),
    .lo     (mx_lo)
  );

  skf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  ({1'b0, p1_r}),
    .mplier (omk),
    .done   (mp_done),
    .acc    (mp_acc),
    .lo     (mp_lo)
  );

  // estimate update: round half up, then saturate to 24 bits
  always_comb begin
    xn_wide = {{4{x_r[DATA_W-1]}}, x_r}
            + {{1{mx_acc[ACC_W-1]}}, mx_acc, 1'b0}
            + (DATA_W+4)'(mx_lo[FRAC_BITS])
            + (DATA_W+4)'(mx_lo[FRAC_BITS-1]);
    if (xn_wide > S24_MAX) begin
      xn = S24_MAX[DATA_W-1:0];
    end else if (xn_wide < S24_MIN) begin
      xn = S24_MIN[DATA_W-1:0];
    end else begin
      xn = xn_wide[DATA_W-1:0];
    end
  end

  // covariance update, always fits 24 bits
  assign pn = {mp_acc[DATA_W-2:0], mp_lo[FRAC_BITS]};

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign div_start = (state_r == S_LOAD) && ch_ok && (den != '0);
  assign mul_start = (state_r == S_DIV) && div_done;
  assign wr_state  = (state_r == S_MUL) && mx_done;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    m_nxt         = m_r;
    x_nxt         = x_r;
    p1_nxt        = p1_r;
    res_nxt       = res_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt    = in_word.channel;
          m_nxt     = in_word.measurement;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        x_nxt  = x_rd;
        p1_nxt = p1;
        res_nxt.channel_out = ch_r;
        if (!ch_ok) begin
          res_nxt.estimate = '0;
          res_nxt.error    = 1'b1;
          state_nxt        = S_FIN;
        end else if (den == '0) begin
          res_nxt.estimate = x_rd;
          res_nxt.error    = 1'b1;
          state_nxt        = S_FIN;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mx_done) begin
          res_nxt.estimate = xn;
          res_nxt.error    = 1'b0;
          state_nxt        = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_word_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // channel state, written back at the end of an update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        est_r[i] <= est_reset(i);
        cov_r[i] <= COV_RST;
      end
    end else if (wr_state) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (int'(ch_r) == i) begin
          est_r[i] <= xn;
          cov_r[i] <= pn;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    m_r        <= m_nxt;
    x_r        <= x_nxt;
    p1_r       <= p1_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // the gain never exceeds one
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (k <= ONE))
    else $error("gain above one");

  // both update multipliers finish together, only while updating
  a_mul_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (mx_done == mp_done) && (!mx_done || state_r == S_MUL))
    else $error("update multipliers out of step");

  // divider results only arrive while waiting on the divider
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside divide phase");

  // a finished result with a free output register shows up next cycle
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid && state_r == S_IDLE))
    else $error("result not delivered");

  // a zero divisor never reaches the divider
  a_no_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (den != '0))
    else $error("divider started with zero divisor");

endmodule

`default_nettype wire
